@@ sv/sttm_pkg.sv @@
`timescale 1ns / 1ps

package sttm_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned CNT_W    = 17;
    localparam int unsigned WDPS_W   = 7;
    localparam int unsigned MODE16_W = 16;
    localparam int unsigned STAT_W   = 4;

    localparam logic [CNT_W-1:0]  CNT_FULL    = 17'h10000;
    localparam logic [DATA_W-1:0] WD_MODE_RST = 32'h0002_0000;
    localparam logic [MODE16_W-1:0] RT_MODE_RST = 16'h8000;
    localparam int unsigned       WD_RST_EN_BIT = 16;

    localparam int unsigned ST_PIT   = 0;
    localparam int unsigned ST_WDOVF = 1;
    localparam int unsigned ST_RTINC = 2;
    localparam int unsigned ST_ALARM = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } t_kind;

    typedef enum logic [IDX_W-1:0] {
        REG_CR   = 4'd0,
        REG_PIMR = 4'd1,
        REG_WDMR = 4'd2,
        REG_RTMR = 4'd3,
        REG_SR   = 4'd4,
        REG_IER  = 4'd5,
        REG_IDR  = 4'd6,
        REG_IMR  = 4'd7,
        REG_RTAR = 4'd8,
        REG_CRTR = 4'd9
    } t_reg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              irq;
        logic              wd_reset;
    } t_step_res;

    // low 16 bits, zero stands for 65536
    function automatic logic [CNT_W-1:0] reload_of(input logic [MODE16_W-1:0] v);
        reload_of = (v == '0) ? CNT_FULL : {1'b0, v};
    endfunction

endpackage

@@ sv/sttm_if.sv @@
`timescale 1ns / 1ps

interface sttm_in_if;
    import sttm_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [IDX_W-1:0]    reg_index;
    logic [DATA_W-1:0]   wdata;

    modport source (output valid, output kind, output reg_index, output wdata, input ready);
    modport sink   (input valid, input kind, input reg_index, input wdata, output ready);
endinterface

interface sttm_out_if;
    import sttm_pkg::*;
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   rdata;
    logic                irq;
    logic                wd_reset;

    modport source (output valid, output rdata, output irq, output wd_reset, input ready);
    modport sink   (input valid, input rdata, input irq, input wd_reset, output ready);
endinterface

@@ sv/sttm_engine.sv @@
`timescale 1ns / 1ps

module sttm_engine
    import sttm_pkg::*;
#(
    parameter int unsigned RT_WIDTH = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [IDX_W-1:0]  i_reg_index,
    input  logic [DATA_W-1:0] i_wdata,
    output t_step_res         o_res
);

    logic [DATA_W-1:0]   r_pit_mode,    n_pit_mode;
    logic [CNT_W-1:0]    r_pit_count,   n_pit_count;
    logic [DATA_W-1:0]   r_wd_mode,     n_wd_mode;
    logic [CNT_W-1:0]    r_wd_count,    n_wd_count;
    logic [WDPS_W-1:0]   r_wd_prescale, n_wd_prescale;
    logic [MODE16_W-1:0] r_rt_mode,     n_rt_mode;
    logic [CNT_W-1:0]    r_rt_prescale, n_rt_prescale;
    logic [RT_WIDTH-1:0] r_rt_value,    n_rt_value;
    logic [RT_WIDTH-1:0] r_alarm,       n_alarm;
    logic [STAT_W-1:0]   r_status,      n_status;
    logic [STAT_W-1:0]   r_mask,        n_mask;

    logic [CNT_W-1:0]    rt_inc;
    logic [RT_WIDTH:0]   rt_next;
    logic [DATA_W-1:0]   rdata;
    logic                pulse;

    assign rt_inc  = r_rt_prescale + CNT_W'(1);
    assign rt_next = {1'b0, r_rt_value} + (RT_WIDTH+1)'(1);

    always_comb begin
        n_pit_mode    = r_pit_mode;
        n_pit_count   = r_pit_count;
        n_wd_mode     = r_wd_mode;
        n_wd_count    = r_wd_count;
        n_wd_prescale = r_wd_prescale;
        n_rt_mode     = r_rt_mode;
        n_rt_prescale = r_rt_prescale;
        n_rt_value    = r_rt_value;
        n_alarm       = r_alarm;
        n_status      = r_status;
        n_mask        = r_mask;
        rdata         = '0;
        pulse         = 1'b0;

        case (t_kind'(i_kind))
            KIND_TICK: begin
                if (r_pit_count <= CNT_W'(1)) begin
                    n_pit_count      = reload_of(r_pit_mode[MODE16_W-1:0]);
                    n_status[ST_PIT] = 1'b1;
                end else begin
                    n_pit_count = r_pit_count - CNT_W'(1);
                end

                n_wd_prescale = r_wd_prescale + WDPS_W'(1);
                if (n_wd_prescale == '0) begin
                    if (r_wd_count <= CNT_W'(1)) begin
                        n_wd_count         = reload_of(r_wd_mode[MODE16_W-1:0]);
                        n_status[ST_WDOVF] = 1'b1;
                        pulse              = r_wd_mode[WD_RST_EN_BIT];
                    end else begin
                        n_wd_count = r_wd_count - CNT_W'(1);
                    end
                end

                if (rt_inc >= reload_of(r_rt_mode)) begin
                    n_rt_prescale      = '0;
                    n_rt_value         = rt_next[RT_WIDTH-1:0];
                    n_status[ST_RTINC] = 1'b1;
                    if (rt_next == {1'b0, r_alarm}) begin
                        n_status[ST_ALARM] = 1'b1;
                    end
                end else begin
                    n_rt_prescale = rt_inc;
                end
            end
            KIND_READ: begin
                unique case (t_reg_idx'(i_reg_index))
                    REG_PIMR: rdata = r_pit_mode;
                    REG_WDMR: rdata = r_wd_mode;
                    REG_RTMR: rdata = DATA_W'(r_rt_mode);
                    REG_SR: begin
                        rdata    = DATA_W'(r_status);
                        n_status = '0;
                    end
                    REG_IMR:  rdata = DATA_W'(r_mask);
                    REG_RTAR: rdata = DATA_W'(r_alarm);
                    REG_CRTR: rdata = DATA_W'(r_rt_value);
                    default:  rdata = '0;
                endcase
            end
            KIND_WRITE: begin
                unique case (t_reg_idx'(i_reg_index))
                    REG_CR: begin
                        if (i_wdata[0]) begin
                            n_wd_count = reload_of(r_wd_mode[MODE16_W-1:0]);
                        end
                    end
                    REG_PIMR: begin
                        n_pit_mode  = i_wdata;
                        n_pit_count = reload_of(i_wdata[MODE16_W-1:0]);
                    end
                    REG_WDMR: n_wd_mode = i_wdata;
                    REG_RTMR: begin
                        n_rt_mode     = i_wdata[MODE16_W-1:0];
                        n_rt_value    = '0;
                        n_rt_prescale = '0;
                    end
                    REG_IER:  n_mask = r_mask | i_wdata[STAT_W-1:0];
                    REG_IDR:  n_mask = r_mask & ~i_wdata[STAT_W-1:0];
                    REG_RTAR: n_alarm = i_wdata[RT_WIDTH-1:0];
                    default:  n_mask = r_mask;
                endcase
            end
            default: rdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pit_mode    <= '0;
            r_pit_count   <= CNT_FULL;
            r_wd_mode     <= WD_MODE_RST;
            r_wd_count    <= CNT_FULL;
            r_wd_prescale <= '0;
            r_rt_mode     <= RT_MODE_RST;
            r_rt_prescale <= '0;
            r_rt_value    <= '0;
            r_alarm       <= '0;
            r_status      <= '0;
            r_mask        <= '0;
        end else if (i_step) begin
            r_pit_mode    <= n_pit_mode;
            r_pit_count   <= n_pit_count;
            r_wd_mode     <= n_wd_mode;
            r_wd_count    <= n_wd_count;
            r_wd_prescale <= n_wd_prescale;
            r_rt_mode     <= n_rt_mode;
            r_rt_prescale <= n_rt_prescale;
            r_rt_value    <= n_rt_value;
            r_alarm       <= n_alarm;
            r_status      <= n_status;
            r_mask        <= n_mask;
        end
    end

    assign o_res.rdata    = rdata;
    assign o_res.irq      = |(n_status & n_mask);
    assign o_res.wd_reset = pulse;

endmodule

@@ sv/system_timer_pit_wdt_rtt_core.sv @@
`timescale 1ns / 1ps
// channel | dir | payload                     | handshake
// i_in    | in  | kind, reg_index, wdata      | valid/ready
// o_out   | out | rdata, irq, wd_reset        | valid/ready
//
// One word per cycle while o_out.ready is high; stages: input register, result register.
// Timer state is updated as a word moves from the input register to the result register.
// i_rst_n is synchronous, active low; it restores all timer registers and empties both stages.
// A stalled output holds its word while the input register keeps a word waiting;
// i_in.ready drops only when both stages are full and o_out.ready is low.

module system_timer_pit_wdt_rtt_core
    import sttm_pkg::*;
#(
    parameter int unsigned RT_WIDTH = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sttm_in_if.sink    i_in,
    sttm_out_if.source o_out
);

    logic              r_in_valid;
    logic [KIND_W-1:0] r_kind;
    logic [IDX_W-1:0]  r_reg_index;
    logic [DATA_W-1:0] r_wdata;
    logic              r_out_valid;
    t_step_res         r_res;
    t_step_res         step_res;
    logic              advance;
    logic              in_take;

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_take  = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || advance;

    sttm_engine #(
        .RT_WIDTH (RT_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_kind      (r_kind),
        .i_reg_index (r_reg_index),
        .i_wdata     (r_wdata),
        .o_res       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind      <= i_in.kind;
            r_reg_index <= i_in.reg_index;
            r_wdata     <= i_in.wdata;
        end
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.rdata    = r_res.rdata;
    assign o_out.irq      = r_res.irq;
    assign o_out.wd_reset = r_res.wd_reset;

endmodule

@@ bench/system_timer_pit_wdt_rtt_core_test.sv @@
`timescale 1ns / 1ps

module system_timer_pit_wdt_rtt_core_test;
    import sttm_pkg::*;

    localparam int unsigned RT_W        = 20;
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned RANDOM_WORDS = 400;
    localparam int unsigned TAIL_TICKS  = 300;

    localparam logic [KIND_W-1:0] KIND_NONE       = 2'd3;
    localparam logic [IDX_W-1:0]  REG_SPARE_FIRST = 4'd10;
    localparam logic [IDX_W-1:0]  REG_SPARE_LAST  = 4'd15;

    class timer_scoreboard;
        logic [DATA_W-1:0]   pit_mode;
        logic [CNT_W-1:0]    pit_count;
        logic [DATA_W-1:0]   wd_mode;
        logic [CNT_W-1:0]    wd_count;
        logic [WDPS_W-1:0]   wd_prescale;
        logic [MODE16_W-1:0] rt_mode;
        logic [CNT_W-1:0]    rt_prescale;
        logic [RT_W-1:0]     rt_value;
        logic [RT_W-1:0]     alarm_value;
        logic [STAT_W-1:0]   status;
        logic [STAT_W-1:0]   int_mask;
        t_step_res           pending_results[$];
        int unsigned errors, words, ticks, reads, writes, others, resets, alarms, wraps;

        function new();
            pit_mode    = '0;
            pit_count   = CNT_FULL;
            wd_mode     = WD_MODE_RST;
            wd_count    = CNT_FULL;
            wd_prescale = '0;
            rt_mode     = RT_MODE_RST;
            rt_prescale = '0;
            rt_value    = '0;
            alarm_value = '0;
            status      = '0;
            int_mask    = '0;
            errors = 0; words = 0; ticks = 0; reads = 0; writes = 0;
            others = 0; resets = 0; alarms = 0; wraps = 0;
        endfunction

        function logic [CNT_W-1:0] count_reload(logic [MODE16_W-1:0] v);
            return (v == 0) ? CNT_FULL : CNT_W'(v);
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function logic apply_tick();
            logic        pulse;
            logic [RT_W:0] next_rt;
            pulse = 1'b0;
            if (pit_count <= 1) begin
                pit_count      = count_reload(pit_mode[15:0]);
                status[ST_PIT] = 1'b1;
            end else begin
                pit_count = pit_count - 1;
            end
            // watchdog steps once per 128 ticks
            wd_prescale = wd_prescale + 1;
            if (wd_prescale == 0) begin
                if (wd_count <= 1) begin
                    wd_count         = count_reload(wd_mode[15:0]);
                    status[ST_WDOVF] = 1'b1;
                    pulse            = wd_mode[WD_RST_EN_BIT];
                end else begin
                    wd_count = wd_count - 1;
                end
            end
            rt_prescale = rt_prescale + 1;
            if (rt_prescale >= count_reload(rt_mode)) begin
                rt_prescale = '0;
                next_rt     = {1'b0, rt_value} + 1'b1;
                if (next_rt == {1'b0, alarm_value}) begin
                    status[ST_ALARM] = 1'b1;
                    alarms++;
                end
                if (next_rt[RT_W]) wraps++;
                rt_value         = next_rt[RT_W-1:0];
                status[ST_RTINC] = 1'b1;
            end
            return pulse;
        endfunction

        function logic [DATA_W-1:0] read_reg(logic [IDX_W-1:0] idx);
            logic [DATA_W-1:0] r;
            r = '0;
            case (idx)
                REG_PIMR: r = pit_mode;
                REG_WDMR: r = wd_mode;
                REG_RTMR: r = DATA_W'(rt_mode);
                REG_SR: begin
                    r      = DATA_W'(status);
                    status = '0;
                end
                REG_IMR:  r = DATA_W'(int_mask);
                REG_RTAR: r = DATA_W'(alarm_value);
                REG_CRTR: r = DATA_W'(rt_value);
                default: ;
            endcase
            return r;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] v);
            case (idx)
                REG_CR: begin
                    if (v[0]) wd_count = count_reload(wd_mode[15:0]);
                end
                REG_PIMR: begin
                    pit_mode  = v;
                    pit_count = count_reload(v[15:0]);
                end
                REG_WDMR: wd_mode = v;
                REG_RTMR: begin
                    rt_mode     = v[15:0];
                    rt_value    = '0;
                    rt_prescale = '0;
                end
                REG_IER:  int_mask = int_mask | v[STAT_W-1:0];
                REG_IDR:  int_mask = int_mask & ~v[STAT_W-1:0];
                REG_RTAR: alarm_value = v[RT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_word(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                                logic [DATA_W-1:0] wdata);
            t_step_res r;
            r = '0;
            case (kind)
                KIND_TICK: begin
                    r.wd_reset = apply_tick();
                    ticks++;
                    if (r.wd_reset) resets++;
                end
                KIND_READ: begin
                    r.rdata = read_reg(idx);
                    reads++;
                end
                KIND_WRITE: begin
                    write_reg(idx, wdata);
                    writes++;
                end
                default: others++;
            endcase
            r.irq = |(status & int_mask);
            pending_results.push_back(r);
        endfunction

        function void check_word(logic [DATA_W-1:0] rdata, logic irq, logic wd_reset);
            t_step_res exp_res;
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: rdata=%h irq=%b wd_reset=%b",
                       rdata, irq, wd_reset);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            words++;
            if (rdata !== exp_res.rdata) begin
                $error("rdata: expected %h, actual %h", exp_res.rdata, rdata);
                errors++;
            end
            if (irq !== exp_res.irq) begin
                $error("irq: expected %b, actual %b", exp_res.irq, irq);
                errors++;
            end
            if (wd_reset !== exp_res.wd_reset) begin
                $error("wd_reset: expected %b, actual %b", exp_res.wd_reset, wd_reset);
                errors++;
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    bit              gaps_on;
    bit              stalls_on;
    int unsigned     hold_cycles;
    int unsigned     cycle_count;
    timer_scoreboard sb;

    sttm_in_if  in_ch();
    sttm_out_if out_ch();

    system_timer_pit_wdt_rtt_core #(
        .RT_WIDTH(RT_W)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words outstanding",
                 cycle_count, sb.pending());
        $display("[system_timer_pit_wdt_rtt_core] ERROR");
        $finish;
    end

    // result side: random stalls, plus one long hold on request
    initial begin
        int unsigned n;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles != 0) begin
                out_ch.ready <= 1'b0;
                n           = hold_cycles;
                hold_cycles = 0;
                repeat (n - 1) @(negedge clk);
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready)
            sb.check_word(out_ch.rdata, out_ch.irq, out_ch.wd_reset);
    end

    task automatic send_word(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] d);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= k;
        in_ch.reg_index <= idx;
        in_ch.wdata     <= d;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        sb.note_word(k, idx, d);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    function automatic logic [IDX_W-1:0] random_index();
        if ($urandom_range(0, 7) == 0)
            return IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST));
        return IDX_W'($urandom_range(REG_CR, REG_CRTR));
    endfunction

    // small reloads keep the counters firing often
    function automatic logic [DATA_W-1:0] write_value(logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] d;
        d = $urandom();
        case (idx)
            REG_PIMR, REG_WDMR, REG_RTMR: begin
                case ($urandom_range(0, 5))
                    0: d[15:0] = 16'h0000;
                    1: d[15:0] = 16'hffff;
                    5: ;
                    default: d[15:0] = 16'($urandom_range(1, 6));
                endcase
            end
            REG_RTAR: begin
                if ($urandom_range(0, 3) != 0)
                    d = DATA_W'(sb.rt_value) + DATA_W'($urandom_range(1, 4));
            end
            default: ;
        endcase
        return d;
    endfunction

    task automatic send_random(output int unsigned count);
        int unsigned      pick;
        logic [IDX_W-1:0] idx;
        pick  = $urandom_range(0, 99);
        idx   = random_index();
        count = 1;
        if (pick < 2) begin
            count = $urandom_range(20, 140);
            repeat (count) send_word(KIND_TICK, IDX_W'($urandom()), $urandom());
        end else if (pick < 45) begin
            send_word(KIND_TICK, idx, $urandom());
        end else if (pick < 65) begin
            send_word(KIND_READ, idx, $urandom());
        end else if (pick < 97) begin
            send_word(KIND_WRITE, idx, write_value(idx));
        end else begin
            send_word(KIND_NONE, idx, $urandom());
        end
    endtask

    initial begin
        int unsigned sent;
        int unsigned n;
        int unsigned next_switch;
        sb              = new();
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_TICK;
        in_ch.reg_index = REG_CR;
        in_ch.wdata     = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values, unknown kind and index, ignored writes
        send_word(KIND_READ, REG_SR, '1);
        send_word(KIND_READ, REG_WDMR, '0);
        send_word(KIND_READ, REG_RTMR, '0);
        send_word(KIND_READ, REG_SPARE_LAST, '0);
        send_word(KIND_NONE, REG_PIMR, '1);
        send_word(KIND_WRITE, REG_PIMR, 32'hffff_ffff);
        send_word(KIND_READ, REG_PIMR, '0);
        send_word(KIND_WRITE, REG_PIMR, 32'h0000_0001);
        send_word(KIND_TICK, REG_SPARE_FIRST, '1);
        send_word(KIND_WRITE, REG_IER, 32'hffff_ffff);
        send_word(KIND_READ, REG_IMR, '0);
        send_word(KIND_WRITE, REG_RTMR, 32'hffff_0001);
        send_word(KIND_WRITE, REG_RTAR, 32'hfff0_0002);
        send_word(KIND_TICK, REG_CR, '0);
        send_word(KIND_TICK, REG_CR, '0);
        send_word(KIND_READ, REG_CRTR, '0);
        send_word(KIND_READ, REG_SR, '0);
        send_word(KIND_WRITE, REG_IDR, 32'h0000_0005);
        send_word(KIND_WRITE, REG_WDMR, 32'h0001_0001);
        send_word(KIND_WRITE, REG_CR, 32'hffff_fffe);
        send_word(KIND_WRITE, REG_CR, 32'h0000_0001);
        send_word(KIND_WRITE, REG_IMR, 32'hffff_ffff);
        send_word(KIND_WRITE, REG_CRTR, 32'hffff_ffff);
        send_word(KIND_WRITE, REG_SR, 32'hffff_ffff);
        send_word(KIND_WRITE, REG_SPARE_LAST, 32'hffff_ffff);
        send_word(KIND_WRITE, REG_PIMR, 32'h0000_0000);
        send_word(KIND_WRITE, REG_RTAR, '0);
        send_word(KIND_WRITE, REG_RTMR, '0);
        send_word(KIND_READ, REG_RTAR, '0);
        send_word(KIND_READ, REG_RTMR, '0);
        wait_drained();

        // output held off long enough to back up the input
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;
        hold_cycles = 60;
        repeat (16) send_random(n);
        wait_drained();

        sent        = 0;
        next_switch = 0;
        while (sent < RANDOM_WORDS) begin
            if (sent >= next_switch) begin
                gaps_on     = $urandom_range(0, 2) != 0;
                stalls_on   = $urandom_range(0, 2) != 0;
                next_switch = sent + 100;
            end
            send_random(n);
            sent += n;
        end
        wait_drained();

        // back to back to the end: alarm, periodic and watchdog reset pulse at one step per tick
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_word(KIND_WRITE, REG_IER, 32'h0000_000f);
        send_word(KIND_WRITE, REG_PIMR, 32'h0000_0007);
        send_word(KIND_WRITE, REG_WDMR, 32'h0001_0002);
        send_word(KIND_WRITE, REG_CR, 32'h0000_0001);
        send_word(KIND_WRITE, REG_RTAR, 32'h0000_0080);
        send_word(KIND_WRITE, REG_RTMR, 32'h0000_0001);
        for (int unsigned t = 0; t < TAIL_TICKS; t++) begin
            if (t % 64 == 0) send_word(KIND_READ, REG_SR, $urandom());
            send_word(KIND_TICK, IDX_W'($urandom()), $urandom());
        end
        send_word(KIND_READ, REG_CRTR, '0);
        send_word(KIND_READ, REG_SR, '0);

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        $display("Covered %0d words: %0d ticks, %0d reads, %0d writes, %0d no-ops;",
                 sb.words, sb.ticks, sb.reads, sb.writes, sb.others);
        $display("  %0d watchdog reset pulses, %0d alarms, %0d counter wraps, %0d mismatches.",
                 sb.resets, sb.alarms, sb.wraps, sb.errors);
        if (sb.errors == 0)
            $display("[system_timer_pit_wdt_rtt_core] OK");
        else
            $display("[system_timer_pit_wdt_rtt_core] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
sv/sttm_pkg.sv
sv/sttm_if.sv
sv/sttm_engine.sv
sv/system_timer_pit_wdt_rtt_core.sv
bench/system_timer_pit_wdt_rtt_core_test.sv
